### src/cpvm_pkg.sv
// ----------------------------------------------------------------------------
// cpvm_pkg
// Shared types, constants and helpers for the contour polygon vertex merger.
// ----------------------------------------------------------------------------
package cpvm_pkg;

  localparam int GRID_ROWS    = 64;
  localparam int GRID_COLS    = 64;
  localparam int MAX_VERTICES = 8;
  localparam int NUM_KINDS    = 5;

  localparam int COORD_W = 6;
  localparam int PKIND_W = 3;
  localparam int VTX_W   = 2 * COORD_W + PKIND_W;
  localparam int LINK_W  = 2 * VTX_W;
  localparam int ENT_W   = LINK_W + 1;

  localparam int STORE_DEPTH = GRID_ROWS * GRID_COLS * NUM_KINDS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int IDX_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W       = $clog2(MAX_VERTICES + 1);

  localparam logic [PKIND_W-1:0] PKIND_MAX = PKIND_W'(NUM_KINDS - 1);

  typedef logic [VTX_W-1:0] vtx_t;

  typedef enum logic [2:0] {
    STAT_NEW       = 3'd0,
    STAT_DROPPED   = 3'd1,
    STAT_MERGE_NXT = 3'd2,
    STAT_MERGE_PRV = 3'd3,
    STAT_CONFLICT  = 3'd4,
    STAT_RD_OCC    = 3'd5,
    STAT_RD_EMPTY  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_LK_CUR,
    S_LK_PRV,
    S_LK_NXT,
    S_WR
  } state_t;

  function automatic logic [ADDR_W-1:0] store_addr(input vtx_t v);
    logic [ADDR_W-1:0] cell_idx;
    cell_idx = ADDR_W'(v[VTX_W-1 -: COORD_W]) * ADDR_W'(GRID_COLS)
             + ADDR_W'(v[PKIND_W +: COORD_W]);
    return ADDR_W'(cell_idx * ADDR_W'(NUM_KINDS) + ADDR_W'(v[PKIND_W-1:0]));
  endfunction

endpackage

### src/contour_polygon_vertex_merger.sv
// ----------------------------------------------------------------------------
// contour_polygon_vertex_merger
// Buffers the vertices of one elementary polygon, merges their neighbour
// links into a grid link store and reports one status per vertex; a read
// request returns one stored entry.
//
//   channel | ports            | direction | transfer when
//   input   | in_valid/in_*    | in        | in_valid & !in_stall
//   result  | out_valid/out_*  | out       | out_valid & !out_stall
//
// after reset the link store is cleared, one entry a cycle, with in_stall
// high. a closing vertex runs one lookup per buffered vertex (three vertex
// buffer reads and one store read per lookup), then one store write per
// result. out_stall holds the sequencer in its read or write step.
// ----------------------------------------------------------------------------
module contour_polygon_vertex_merger (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_kind,
  input  logic [5:0]             in_row,
  input  logic [5:0]             in_col,
  input  logic [2:0]             in_point_kind,
  input  logic                   in_last,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [5:0]             out_row,
  output logic [5:0]             out_col,
  output logic [2:0]             out_kind,
  output cpvm_pkg::status_t      out_status,
  output logic [5:0]             out_prev_row,
  output logic [5:0]             out_prev_col,
  output logic [2:0]             out_prev_kind,
  output logic [5:0]             out_next_row,
  output logic [5:0]             out_next_col,
  output logic [2:0]             out_next_kind,
  output logic                   out_final_res
);
  import cpvm_pkg::*;

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  vtx_t               cur_r, cur_nxt;
  vtx_t               pv_r, pv_nxt;
  vtx_t               vbuf_r [MAX_VERTICES];
  logic [ENT_W-1:0]   res_ent_r [MAX_VERTICES];
  status_t            res_stat_r [MAX_VERTICES];

  logic               out_valid_r, out_valid_nxt;
  vtx_t               out_vtx_r, out_vtx_nxt;
  status_t            out_stat_r, out_stat_nxt;
  logic [LINK_W-1:0]  out_link_r, out_link_nxt;
  logic               out_fin_r, out_fin_nxt;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ENT_W-1:0]   ram_wdata, ram_rdata;

  logic               in_xfer, out_free, clr_done, idx_is_end;
  logic [COORD_W-1:0] norm_row, norm_col;
  logic [PKIND_W-1:0] norm_kind;
  vtx_t               in_vtx, buf_rd;
  logic [IDX_W-1:0]   buf_idx, prv_idx, nxt_idx;
  logic               vbuf_we, res_we;
  vtx_t               sp, sn, mrg_pv, mrg_nx;
  status_t            mrg_stat;

  cpvm_ram #(
    .WIDTH(ENT_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // input normalization
  assign norm_row  = COORD_W'(32'(in_row) % GRID_ROWS);
  assign norm_col  = COORD_W'(32'(in_col) % GRID_COLS);
  assign norm_kind = (in_point_kind > PKIND_MAX) ? PKIND_MAX : in_point_kind;
  assign in_vtx    = {norm_row, norm_col, norm_kind};

  assign in_stall   = (state_r != S_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign clr_done   = (clr_addr_r == ADDR_W'(STORE_DEPTH - 1));
  assign idx_is_end = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);
  assign prv_idx    = (idx_r == '0) ? IDX_W'(cnt_r - CNT_W'(1)) : IDX_W'(idx_r - IDX_W'(1));
  assign nxt_idx    = idx_is_end ? '0 : IDX_W'(idx_r + IDX_W'(1));

  always_comb begin
    unique case (state_r)
      S_LK_PRV: buf_idx = prv_idx;
      S_LK_NXT: buf_idx = nxt_idx;
      default:  buf_idx = idx_r;
    endcase
  end

  assign buf_rd = vbuf_r[buf_idx];

  // merge of the new links with the stored entry
  assign sp = ram_rdata[LINK_W-1:VTX_W];
  assign sn = ram_rdata[VTX_W-1:0];

  always_comb begin
    mrg_pv   = pv_r;
    mrg_nx   = buf_rd;
    mrg_stat = STAT_NEW;
    if (ram_rdata[ENT_W-1]) begin
      priority if (buf_rd == sp && pv_r == sn) begin
        mrg_stat = STAT_DROPPED;
      end else if (buf_rd == sp) begin
        mrg_nx   = sn;
        mrg_stat = STAT_MERGE_NXT;
      end else if (pv_r == sn) begin
        mrg_pv   = sp;
        mrg_stat = STAT_MERGE_PRV;
      end else begin
        mrg_stat = STAT_CONFLICT;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) begin
          priority if (in_kind) state_nxt = S_RD;
          else if (in_last)     state_nxt = S_LK_CUR;
          else                  state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_LK_CUR: state_nxt = S_LK_PRV;
      S_LK_PRV: state_nxt = S_LK_NXT;
      S_LK_NXT: state_nxt = idx_is_end ? S_WR : S_LK_CUR;
      S_WR: begin
        if (out_free && idx_is_end) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    clr_addr_nxt  = clr_addr_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    cur_nxt       = cur_r;
    pv_nxt        = pv_r;
    vbuf_we       = 1'b0;
    res_we        = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = store_addr(buf_rd);
    ram_wdata     = res_ent_r[idx_r];
    ram_re        = 1'b0;
    ram_raddr     = store_addr(buf_rd);
    out_valid_nxt = out_valid_r && out_stall;
    out_vtx_nxt   = out_vtx_r;
    out_stat_nxt  = out_stat_r;
    out_link_nxt  = out_link_r;
    out_fin_nxt   = out_fin_r;
    unique case (state_r)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = ADDR_W'(clr_addr_r + ADDR_W'(1));
      end
      S_IDLE: begin
        if (in_xfer) begin
          cur_nxt = in_vtx;
          idx_nxt = '0;
          if (in_kind) begin
            ram_re    = 1'b1;
            ram_raddr = store_addr(in_vtx);
          end else if (cnt_r < CNT_W'(MAX_VERTICES)) begin
            vbuf_we = 1'b1;
            cnt_nxt = CNT_W'(cnt_r + CNT_W'(1));
          end
        end
      end
      S_RD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_vtx_nxt   = cur_r;
          out_fin_nxt   = 1'b1;
          if (ram_rdata[ENT_W-1]) begin
            out_stat_nxt = STAT_RD_OCC;
            out_link_nxt = ram_rdata[LINK_W-1:0];
          end else begin
            out_stat_nxt = STAT_RD_EMPTY;
            out_link_nxt = '0;
          end
        end
      end
      S_LK_CUR: begin
        ram_re = 1'b1;
      end
      S_LK_PRV: begin
        pv_nxt = buf_rd;
      end
      S_LK_NXT: begin
        res_we  = 1'b1;
        idx_nxt = idx_is_end ? '0 : IDX_W'(idx_r + IDX_W'(1));
      end
      S_WR: begin
        if (out_free) begin
          ram_we        = 1'b1;
          out_valid_nxt = 1'b1;
          out_vtx_nxt   = buf_rd;
          out_stat_nxt  = res_stat_r[idx_r];
          out_link_nxt  = res_ent_r[idx_r][LINK_W-1:0];
          out_fin_nxt   = idx_is_end;
          if (idx_is_end) begin
            cnt_nxt = '0;
            idx_nxt = '0;
          end else begin
            idx_nxt = IDX_W'(idx_r + IDX_W'(1));
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    pv_r       <= pv_nxt;
    out_vtx_r  <= out_vtx_nxt;
    out_stat_r <= out_stat_nxt;
    out_link_r <= out_link_nxt;
    out_fin_r  <= out_fin_nxt;
    if (vbuf_we) begin
      vbuf_r[cnt_r[IDX_W-1:0]] <= in_vtx;
    end
    if (res_we) begin
      res_stat_r[idx_r] <= mrg_stat;
      res_ent_r[idx_r]  <= (mrg_stat == STAT_DROPPED) ? '0 : {1'b1, mrg_pv, mrg_nx};
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_vtx_r[VTX_W-1 -: COORD_W];
  assign out_col       = out_vtx_r[PKIND_W +: COORD_W];
  assign out_kind      = out_vtx_r[PKIND_W-1:0];
  assign out_status    = out_stat_r;
  assign out_prev_row  = out_link_r[LINK_W-1 -: COORD_W];
  assign out_prev_col  = out_link_r[VTX_W+PKIND_W +: COORD_W];
  assign out_prev_kind = out_link_r[VTX_W +: PKIND_W];
  assign out_next_row  = out_link_r[VTX_W-1 -: COORD_W];
  assign out_next_col  = out_link_r[PKIND_W +: COORD_W];
  assign out_next_kind = out_link_r[PKIND_W-1:0];
  assign out_final_res = out_fin_r;

endmodule

### src/cpvm_ram.sv
// ----------------------------------------------------------------------------
// cpvm_ram
// Generic single write, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cpvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
